FILE: rtl/bvmm_pkg.sv
// Shared types and constants for the battery voltage mode monitor.
package bvmm_pkg;

    localparam int DATA_W = 12;
    localparam int CNT_W  = 8;
    localparam int REG_IDX_W = 3;

    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_WARNING = 2'd1,
        MODE_SEVERE  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_MEDIAN,
        SEQ_DONE
    } seq_state_t;

    localparam logic [REG_IDX_W-1:0] REG_A_EXIT_HIGH   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_A_EXIT_LOW    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_A_RETURN_LOW  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_A_RETURN_HIGH = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_C_ENTER_HIGH  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_C_ENTER_LOW   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_C_RETURN_LOW  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_C_RETURN_HIGH = 3'd7;

    typedef struct packed {
        logic [DATA_W-1:0] a_exit_high;
        logic [DATA_W-1:0] a_exit_low;
        logic [DATA_W-1:0] a_return_low;
        logic [DATA_W-1:0] a_return_high;
        logic [DATA_W-1:0] c_enter_high;
        logic [DATA_W-1:0] c_enter_low;
        logic [DATA_W-1:0] c_return_low;
        logic [DATA_W-1:0] c_return_high;
    } thresh_t;

    typedef struct packed {
        logic              sample_we;
        logic [DATA_W-1:0] sample_data;
        logic              start;
    } med_ctrl_t;

endpackage

FILE: rtl/bvmm_median.sv
// Sample ring and iterative rank-select median unit, one candidate per cycle.
module bvmm_median
    import bvmm_pkg::*;
#(
    parameter int SAMPLE_COUNT = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  med_ctrl_t         ctrl,
    output logic              done,
    output logic [DATA_W-1:0] median
);

    localparam int N       = SAMPLE_COUNT;
    localparam int IW      = (N > 1) ? $clog2(N) : 1;
    localparam int RW      = $clog2(N + 1);
    localparam int LO_RANK = (N - 1) / 2;
    localparam int HI_RANK = N / 2;

    logic [DATA_W-1:0] ring_reg [N];
    logic [IW-1:0]     wr_idx_reg;
    logic [IW-1:0]     cand_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DATA_W-1:0] lo_reg;
    logic [DATA_W-1:0] hi_reg;

    logic [DATA_W-1:0] cand_val;
    logic [RW-1:0]     rank;
    logic [DATA_W:0]   sum;

    assign cand_val = ring_reg[cand_reg];

    always_comb
    begin
        rank = '0;
        for (int j = 0; j < N; j++)
        begin
            if ((ring_reg[j] < cand_val) ||
                ((ring_reg[j] == cand_val) && (IW'(j) < cand_reg)))
            begin
                rank = rank + RW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < N; k++)
            begin
                ring_reg[k] <= '0;
            end
            wr_idx_reg <= '0;
        end
        else if (ctrl.sample_we)
        begin
            ring_reg[wr_idx_reg] <= ctrl.sample_data;
            if (wr_idx_reg == IW'(N - 1))
            begin
                wr_idx_reg <= '0;
            end
            else
            begin
                wr_idx_reg <= wr_idx_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cand_reg <= '0;
        end
        else
        begin
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                cand_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (cand_reg == IW'(N - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    cand_reg <= '0;
                end
                else
                begin
                    done_reg <= 1'b0;
                    cand_reg <= cand_reg + IW'(1);
                end
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            if (rank == RW'(LO_RANK))
            begin
                lo_reg <= cand_val;
            end
            if (rank == RW'(HI_RANK))
            begin
                hi_reg <= cand_val;
            end
        end
    end

    assign sum    = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign median = sum[DATA_W:1];
    assign done   = done_reg;

endmodule

FILE: rtl/bvmm_mode.sv
// Debounced three-mode voltage window machine.
module bvmm_mode
    import bvmm_pkg::*;
#(
    parameter int RUN_DEBOUNCE   = 10,
    parameter int START_DEBOUNCE = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tick_en,
    input  logic              start_phase,
    input  logic [DATA_W-1:0] median,
    input  thresh_t           thr,
    output mode_t             mode_q
);

    localparam logic [CNT_W-1:0] RUN_LIMIT   = CNT_W'(RUN_DEBOUNCE);
    localparam logic [CNT_W-1:0] START_LIMIT = CNT_W'(START_DEBOUNCE);

    mode_t             mode_reg;
    mode_t             mode_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  count_inc;
    logic [CNT_W-1:0]  limit;
    logic              qual;
    mode_t             target;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NORMAL;
            count_reg <= '0;
        end
        else if (tick_en)
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        limit      = start_phase ? START_LIMIT : RUN_LIMIT;
        count_inc  = count_reg + CNT_W'(1);
        qual       = 1'b0;
        target     = mode_reg;
        mode_next  = mode_reg;
        count_next = count_reg;
        unique case (mode_reg)
            MODE_NORMAL:
            begin
                if ((median >= thr.a_exit_high) || (median < thr.a_exit_low))
                begin
                    qual   = 1'b1;
                    target = MODE_WARNING;
                end
            end
            MODE_WARNING:
            begin
                if ((median < thr.a_return_high) && (median >= thr.a_return_low))
                begin
                    qual   = 1'b1;
                    target = MODE_NORMAL;
                end
                else if ((median >= thr.c_enter_high) || (median < thr.c_enter_low))
                begin
                    qual   = 1'b1;
                    target = MODE_SEVERE;
                end
            end
            MODE_SEVERE:
            begin
                if ((median < thr.c_return_high) && (median >= thr.c_return_low))
                begin
                    qual   = 1'b1;
                    target = MODE_WARNING;
                end
            end
            default:
            begin
                target = MODE_SEVERE;
            end
        endcase

        if ((mode_reg != MODE_NORMAL) && (mode_reg != MODE_WARNING) &&
            (mode_reg != MODE_SEVERE))
        begin
            mode_next = MODE_SEVERE;
        end
        else if (qual)
        begin
            if (count_inc >= limit)
            begin
                mode_next  = target;
                count_next = '0;
            end
            else
            begin
                count_next = count_inc;
            end
        end
        else
        begin
            count_next = '0;
        end
    end

    assign mode_q = mode_reg;

endmodule

FILE: rtl/battery_voltage_mode_monitor_core.sv
// Battery voltage mode monitor: median filter plus debounced voltage window machine.
// Sequence: a sample item is written into the ring and its result follows in SEQ_DONE; a tick item
// starts the median unit (one ring entry ranked per cycle), then updates the mode and goes to SEQ_DONE.
// Flow: one item in flight; in_stall holds off a new item until the last result is taken.
// Reset (rst_n, asynchronous): ring, write index, mode, counter and last median clear;
// thresholds return to their defaults.
module battery_voltage_mode_monitor_core
    import bvmm_pkg::*;
#(
    parameter int SAMPLE_COUNT   = 8,
    parameter int RUN_DEBOUNCE   = 10,
    parameter int START_DEBOUNCE = 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 op,
    input  logic [DATA_W-1:0]    adc_value,
    input  logic                 start_phase,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           mode,
    output logic                 voltage_fault,
    output logic                 link_enable,
    output logic [DATA_W-1:0]    median_value,
    input  logic                 cfg_write_en,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    seq_state_t        state_reg;
    seq_state_t        state_next;
    thresh_t           thr_reg;
    logic              sp_reg;
    logic [DATA_W-1:0] last_median_reg;
    med_ctrl_t         med_ctrl;
    logic              med_done;
    logic [DATA_W-1:0] med_value;
    logic              in_accept;
    logic              tick_en;
    mode_t             mode_q;

    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg.a_exit_high   <= '1;
            thr_reg.a_exit_low    <= '0;
            thr_reg.a_return_low  <= '0;
            thr_reg.a_return_high <= '1;
            thr_reg.c_enter_high  <= '1;
            thr_reg.c_enter_low   <= '0;
            thr_reg.c_return_low  <= '0;
            thr_reg.c_return_high <= '1;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_A_EXIT_HIGH:   thr_reg.a_exit_high   <= cfg_data;
                REG_A_EXIT_LOW:    thr_reg.a_exit_low    <= cfg_data;
                REG_A_RETURN_LOW:  thr_reg.a_return_low  <= cfg_data;
                REG_A_RETURN_HIGH: thr_reg.a_return_high <= cfg_data;
                REG_C_ENTER_HIGH:  thr_reg.c_enter_high  <= cfg_data;
                REG_C_ENTER_LOW:   thr_reg.c_enter_low   <= cfg_data;
                REG_C_RETURN_LOW:  thr_reg.c_return_low  <= cfg_data;
                REG_C_RETURN_HIGH: thr_reg.c_return_high <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= SEQ_IDLE;
            last_median_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (tick_en)
            begin
                last_median_reg <= med_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sp_reg <= start_phase;
        end
    end

    always_comb
    begin
        state_next           = state_reg;
        in_stall             = 1'b1;
        out_valid            = 1'b0;
        tick_en              = 1'b0;
        med_ctrl.sample_we   = 1'b0;
        med_ctrl.sample_data = adc_value;
        med_ctrl.start       = 1'b0;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (op)
                    begin
                        med_ctrl.start = 1'b1;
                        state_next     = SEQ_MEDIAN;
                    end
                    else
                    begin
                        med_ctrl.sample_we = 1'b1;
                        state_next         = SEQ_DONE;
                    end
                end
            end
            SEQ_MEDIAN:
            begin
                if (med_done)
                begin
                    tick_en    = 1'b1;
                    state_next = SEQ_DONE;
                end
            end
            SEQ_DONE:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    bvmm_median #(
        .SAMPLE_COUNT (SAMPLE_COUNT)
    ) u_median (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (med_ctrl),
        .done   (med_done),
        .median (med_value)
    );

    bvmm_mode #(
        .RUN_DEBOUNCE   (RUN_DEBOUNCE),
        .START_DEBOUNCE (START_DEBOUNCE)
    ) u_mode (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_en     (tick_en),
        .start_phase (sp_reg),
        .median      (med_value),
        .thr         (thr_reg),
        .mode_q      (mode_q)
    );

    assign mode          = mode_q;
    assign voltage_fault = (mode_q != MODE_NORMAL);
    assign link_enable   = (mode_q != MODE_SEVERE);
    assign median_value  = last_median_reg;

endmodule

FILE: bench/bvmm_tb_pkg.sv
// Item operation codes shared by the monitor testbench files.
`timescale 1ns / 100ps
package bvmm_tb_pkg;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

endpackage

FILE: bench/bvmm_mode_checker.sv
// Checker for the voltage mode monitor: predicts each item's status and compares it.
`timescale 1ns / 100ps
module bvmm_mode_checker
    import bvmm_pkg::*;
    import bvmm_tb_pkg::*;
#(
    parameter int SAMPLE_COUNT   = 8,
    parameter int RUN_DEBOUNCE   = 10,
    parameter int START_DEBOUNCE = 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic                 op,
    input  logic [DATA_W-1:0]    adc_value,
    input  logic                 start_phase,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [1:0]           mode,
    input  logic                 voltage_fault,
    input  logic                 link_enable,
    input  logic [DATA_W-1:0]    median_value,
    input  logic                 cfg_write_en,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    output int                   pending,
    output int                   mismatches,
    output int                   mode_moves
);

    localparam int RING_USED = (SAMPLE_COUNT > 8) ? 8 : ((SAMPLE_COUNT < 1) ? 1 : SAMPLE_COUNT);

    typedef struct packed {
        mode_t             mode;
        logic              fault;
        logic              link;
        logic [DATA_W-1:0] median;
    } status_t;

    thresh_t           th;
    logic [DATA_W-1:0] ring [8];
    logic [2:0]        widx;
    mode_t             cur_mode;
    logic [CNT_W-1:0]  qual;
    logic [DATA_W-1:0] last_med;
    status_t           expected_status_q [$];
    status_t           want;

    function automatic void count_toward(input mode_t target, input logic [CNT_W-1:0] limit);
        qual = qual + 1'b1;
        if (qual >= limit)
        begin
            cur_mode = target;
            qual = '0;
            mode_moves++;
        end
    endfunction

    function automatic status_t predict_status(input logic op_i, input logic [DATA_W-1:0] adc_i,
                                               input logic sp_i);
        logic [DATA_W-1:0] sorted [8];
        logic [DATA_W-1:0] v;
        logic [DATA_W-1:0] m;
        logic [DATA_W:0]   sum;
        logic [CNT_W-1:0]  limit;
        int                j;
        status_t           s;
        if (op_i == OP_SAMPLE)
        begin
            ring[widx] = adc_i;
            widx = widx + 1'b1;
            if (widx >= RING_USED)
                widx = '0;
        end
        else
        begin
            limit = sp_i ? CNT_W'(START_DEBOUNCE) : CNT_W'(RUN_DEBOUNCE);
            for (int i = 0; i < RING_USED; i++)
                sorted[i] = ring[i];
            for (int i = 1; i < RING_USED; i++)
            begin
                v = sorted[i];
                j = i;
                while (j > 0 && sorted[j-1] > v)
                begin
                    sorted[j] = sorted[j-1];
                    j--;
                end
                sorted[j] = v;
            end
            if (RING_USED % 2 == 0)
            begin
                sum = {1'b0, sorted[RING_USED/2-1]} + {1'b0, sorted[RING_USED/2]};
                m = sum[DATA_W:1];
            end
            else
                m = sorted[RING_USED/2];
            last_med = m;
            case (cur_mode)
                MODE_NORMAL:
                    if (m >= th.a_exit_high || m < th.a_exit_low)
                        count_toward(MODE_WARNING, limit);
                    else
                        qual = '0;
                MODE_WARNING:
                    if (m < th.a_return_high && m >= th.a_return_low)
                        count_toward(MODE_NORMAL, limit);
                    else if (m >= th.c_enter_high || m < th.c_enter_low)
                        count_toward(MODE_SEVERE, limit);
                    else
                        qual = '0;
                MODE_SEVERE:
                    if (m < th.c_return_high && m >= th.c_return_low)
                        count_toward(MODE_WARNING, limit);
                    else
                        qual = '0;
                default:
                    cur_mode = MODE_SEVERE;
            endcase
        end
        s.mode   = cur_mode;
        s.fault  = (cur_mode != MODE_NORMAL);
        s.link   = (cur_mode != MODE_SEVERE);
        s.median = last_med;
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            th.a_exit_high   = 12'd4095;
            th.a_exit_low    = 12'd0;
            th.a_return_low  = 12'd0;
            th.a_return_high = 12'd4095;
            th.c_enter_high  = 12'd4095;
            th.c_enter_low   = 12'd0;
            th.c_return_low  = 12'd0;
            th.c_return_high = 12'd4095;
            for (int i = 0; i < 8; i++)
                ring[i] = '0;
            widx       = '0;
            cur_mode   = MODE_NORMAL;
            qual       = '0;
            last_med   = '0;
            mismatches = 0;
            mode_moves = 0;
            expected_status_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_A_EXIT_HIGH:   th.a_exit_high   = cfg_data;
                    REG_A_EXIT_LOW:    th.a_exit_low    = cfg_data;
                    REG_A_RETURN_LOW:  th.a_return_low  = cfg_data;
                    REG_A_RETURN_HIGH: th.a_return_high = cfg_data;
                    REG_C_ENTER_HIGH:  th.c_enter_high  = cfg_data;
                    REG_C_ENTER_LOW:   th.c_enter_low   = cfg_data;
                    REG_C_RETURN_LOW:  th.c_return_low  = cfg_data;
                    REG_C_RETURN_HIGH: th.c_return_high = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_status_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result item with nothing expected: mode=%0d fault=%0b link=%0b median=%0d",
                                 $realtime, mode, voltage_fault, link_enable, median_value);
                    mismatches++;
                end
                else
                begin
                    want = expected_status_q.pop_front();
                    if (mode !== want.mode || voltage_fault !== want.fault ||
                        link_enable !== want.link || median_value !== want.median)
                    begin
                        if (mismatches < 10)
                            $display("%0t: mismatch: expected mode=%0d fault=%0b link=%0b median=%0d, got mode=%0d fault=%0b link=%0b median=%0d",
                                     $realtime, want.mode, want.fault, want.link, want.median,
                                     mode, voltage_fault, link_enable, median_value);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_status_q.push_back(predict_status(op, adc_value, start_phase));
            pending <= expected_status_q.size();
        end
    end

endmodule

FILE: bench/tb_battery_voltage_mode_monitor_core.sv
// Testbench top for the voltage mode monitor: stimulus, threshold settings and verdict.
`timescale 1ns / 100ps
module tb_battery_voltage_mode_monitor_core;
    import bvmm_pkg::*;
    import bvmm_tb_pkg::*;

    localparam int SAMPLE_COUNT     = 8;
    localparam int RUN_DEBOUNCE     = 10;
    localparam int START_DEBOUNCE   = 2;
    localparam int RANDOM_PER_PHASE = 125;
    localparam int SETTLE_CYCLES    = SAMPLE_COUNT + 4;
    localparam int CYCLE_LIMIT      = 300000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 op = OP_SAMPLE;
    logic [DATA_W-1:0]    adc_value = '0;
    logic                 start_phase = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           mode;
    logic                 voltage_fault;
    logic                 link_enable;
    logic [DATA_W-1:0]    median_value;
    logic                 cfg_write_en = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data = '0;

    int     pending;
    int     mismatches;
    int     mode_moves;
    int     cycles = 0;
    int     samples_sent = 0;
    int     ticks_sent = 0;
    int     settings = 0;
    int     level = 2048;
    int     ticks_left = 0;
    logic   burst_sp = 1'b0;
    logic   calm = 1'b0;

    battery_voltage_mode_monitor_core #(
        .SAMPLE_COUNT   (SAMPLE_COUNT),
        .RUN_DEBOUNCE   (RUN_DEBOUNCE),
        .START_DEBOUNCE (START_DEBOUNCE)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .adc_value     (adc_value),
        .start_phase   (start_phase),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .mode          (mode),
        .voltage_fault (voltage_fault),
        .link_enable   (link_enable),
        .median_value  (median_value),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    bvmm_mode_checker #(
        .SAMPLE_COUNT   (SAMPLE_COUNT),
        .RUN_DEBOUNCE   (RUN_DEBOUNCE),
        .START_DEBOUNCE (START_DEBOUNCE)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .adc_value     (adc_value),
        .start_phase   (start_phase),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .mode          (mode),
        .voltage_fault (voltage_fault),
        .link_enable   (link_enable),
        .median_value  (median_value),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pending       (pending),
        .mismatches    (mismatches),
        .mode_moves    (mode_moves)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[battery_voltage_mode_monitor_core] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(0, 99) < 8);

    task automatic send_item(input logic op_i, input logic [DATA_W-1:0] adc_i, input logic sp_i);
        if (!calm && $urandom_range(0, 99) < 8)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= op_i;
        adc_value   <= adc_i;
        start_phase <= sp_i;
        do
            @(posedge clk);
        while (in_stall);
        if (op_i == OP_TICK)
            ticks_sent++;
        else
            samples_sent++;
    endtask

    // drop valid and wait until every result is back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_thresholds(input thresh_t t);
        logic [REG_IDX_W-1:0] idx [8];
        logic [DATA_W-1:0]    val [8];
        idx = '{REG_A_EXIT_HIGH, REG_A_EXIT_LOW, REG_A_RETURN_LOW, REG_A_RETURN_HIGH,
                REG_C_ENTER_HIGH, REG_C_ENTER_LOW, REG_C_RETURN_LOW, REG_C_RETURN_HIGH};
        val = '{t.a_exit_high, t.a_exit_low, t.a_return_low, t.a_return_high,
                t.c_enter_high, t.c_enter_low, t.c_return_low, t.c_return_high};
        for (int i = 0; i < 8; i++)
        begin
            cfg_write_en <= 1'b1;
            cfg_index    <= idx[i];
            cfg_data     <= val[i];
            @(posedge clk);
        end
        cfg_write_en <= 1'b0;
        settings++;
    endtask

    function automatic thresh_t make_window();
        thresh_t t;
        int      lo;
        int      hi;
        int      edge_in;
        int      edge_out;
        lo       = $urandom_range(200, 1800);
        hi       = $urandom_range(2300, 3900);
        edge_in  = $urandom_range(0, 150);
        edge_out = $urandom_range(50, 180);
        t.a_exit_low    = 12'(lo);
        t.a_exit_high   = 12'(hi);
        t.a_return_low  = 12'(lo + edge_in);
        t.a_return_high = 12'(hi - edge_in);
        t.c_enter_low   = 12'(lo - edge_out);
        t.c_enter_high  = 12'(hi + edge_out);
        edge_in         = $urandom_range(0, 40);
        t.c_return_low  = 12'(lo - edge_out + edge_in);
        t.c_return_high = 12'(hi + edge_out - edge_in);
        return t;
    endfunction

    function automatic int clamp_adc(input int v);
        if (v < 0)
            return 0;
        if (v > 4095)
            return 4095;
        return v;
    endfunction

    // slow-moving level with bursts of ticks so the debounce counters fill up
    task automatic run_random(input int count);
        int   r;
        int   adc;
        logic sp;
        for (int k = 0; k < count; k++)
        begin
            if (ticks_left == 0 && $urandom_range(0, 99) < 12)
            begin
                ticks_left = $urandom_range(1, 14);
                burst_sp   = ($urandom_range(0, 99) < 35);
            end
            if ($urandom_range(0, 99) < 3)
                level = $urandom_range(0, 4095);
            else if ($urandom_range(0, 99) < 10)
                level = clamp_adc(level + int'($urandom_range(0, 200)) - 100);
            if (ticks_left > 0)
            begin
                ticks_left--;
                sp = ($urandom_range(0, 99) < 10) ? !burst_sp : burst_sp;
                send_item(OP_TICK, 12'($urandom_range(0, 4095)), sp);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                    adc = $urandom_range(0, 4095);
                else if (r < 12)
                    adc = 0;
                else if (r < 15)
                    adc = 4095;
                else
                    adc = clamp_adc(level + int'($urandom_range(0, 80)) - 40);
                send_item(OP_SAMPLE, 12'(adc), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial
    begin
        thresh_t t;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default thresholds: tick on an empty ring, then drive through every mode
        send_item(OP_TICK, 12'd4095, 1'b0);
        repeat (8) send_item(OP_SAMPLE, 12'd4095, 1'b0);
        send_item(OP_TICK, 12'd0, 1'b1);
        send_item(OP_TICK, 12'd0, 1'b0);
        send_item(OP_TICK, 12'd0, 1'b1);
        send_item(OP_TICK, 12'd0, 1'b1);
        send_item(OP_TICK, 12'd0, 1'b1);
        repeat (4) send_item(OP_SAMPLE, 12'd0, 1'b1);
        send_item(OP_TICK, 12'd4095, 1'b1);
        send_item(OP_TICK, 12'd4095, 1'b1);
        send_item(OP_TICK, 12'd0, 1'b0);
        send_item(OP_SAMPLE, 12'hAAA, 1'b0);
        send_item(OP_SAMPLE, 12'h555, 1'b1);
        send_item(OP_TICK, 12'd0, 1'b1);
        send_item(OP_TICK, 12'd0, 1'b1);
        drain();

        // all thresholds at zero
        t = '0;
        load_thresholds(t);
        run_random(RANDOM_PER_PHASE);
        drain();

        // all thresholds at full scale
        t = '1;
        load_thresholds(t);
        run_random(RANDOM_PER_PHASE);
        drain();

        // return band and severe condition overlap in warning
        t = make_window();
        t.a_return_low  = 12'd0;
        t.a_return_high = 12'd4095;
        t.c_enter_high  = 12'd0;
        load_thresholds(t);
        run_random(RANDOM_PER_PHASE);
        drain();

        for (int p = 0; p < 5; p++)
        begin
            calm = (p == 2);
            load_thresholds(make_window());
            run_random(RANDOM_PER_PHASE);
            drain();
        end
        calm = 1'b0;

        $display("Covered %0d sample items and %0d tick items over %0d threshold settings,",
                 samples_sent, ticks_sent, settings);
        $display("with %0d mode moves predicted.", mode_moves);
        if (mismatches == 0 && pending == 0)
            $display("[battery_voltage_mode_monitor_core] OK");
        else
            $display("[battery_voltage_mode_monitor_core] ERROR");
        $finish;
    end

endmodule
